@@ rtl/bounded_plane_ray_intersect_defines.svh @@
// Assertion macros shared by the ray/plane intersection RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BOUNDED_PLANE_RAY_INTERSECT_DEFINES_SVH
`define BOUNDED_PLANE_RAY_INTERSECT_DEFINES_SVH

// Same-cycle implication.
`define BPRI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BPRI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bpri_pkg.sv @@
package bpri_pkg;

    // Divider widths: |dn| magnitude, |nn| magnitude, and |nn| * 2^16
    localparam int DEN_W = 36;
    localparam int NN_W  = 37;
    localparam int NUM_W = NN_W + 16;

    // Number of limit-row registers on the configuration port
    localparam int ROW_REGS = 4;

    // Register indexes
    localparam logic [2:0] REG_NORMAL = 3'd0;
    localparam logic [2:0] REG_OFFSET = 3'd1;
    localparam logic [2:0] REG_LCOUNT = 3'd2;
    localparam logic [2:0] REG_ROW0   = 3'd3;
    localparam logic [2:0] REG_TOL    = 3'd7;

    // Result status codes
    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_PAR     = 3'd1;
    localparam logic [2:0] ST_BEHIND  = 3'd2;
    localparam logic [2:0] ST_OUTSIDE = 3'd3;
    localparam logic [2:0] ST_OVF     = 3'd4;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] hit_t;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic               normal_flipped;
    } hit_t;

    typedef struct packed {
        logic signed [15:0] norm_a;
        logic signed [15:0] norm_b;
        logic signed [15:0] norm_c;
        logic signed [31:0] offset;
        logic [2:0]         lim_cnt;
        logic [15:0]        tol;
    } cfg_t;

    // Sideband that rides along the divider
    typedef struct packed {
        ray_t ray;
        logic par;
        logic flip;
        logic qneg;
    } ctx_t;

endpackage

@@ rtl/bpri_cfg.sv @@
module bpri_cfg #(
    parameter int MAX_LIMITS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    output bpri_pkg::cfg_t        cfg,
    output logic [63:0]           rows [MAX_LIMITS]
);

    logic [63:0] normal_reg;
    logic [31:0] offset_reg;
    logic [2:0]  lcount_reg;
    logic [15:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg <= '0;
            offset_reg <= '0;
            lcount_reg <= '0;
            tol_reg    <= 16'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bpri_pkg::REG_NORMAL: normal_reg <= cfg_data;
                bpri_pkg::REG_OFFSET: offset_reg <= cfg_data[31:0];
                bpri_pkg::REG_LCOUNT: lcount_reg <= cfg_data[2:0];
                bpri_pkg::REG_TOL:    tol_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Rows past the register list never get written and stay zero
    for (genvar r = 0; r < MAX_LIMITS; r++)
    begin : g_row
        logic [63:0] row_reg;
        if (r < bpri_pkg::ROW_REGS)
        begin : g_wr
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    row_reg <= '0;
                else if (cfg_we && cfg_index == 3'(int'(bpri_pkg::REG_ROW0) + r))
                    row_reg <= cfg_data;
            end
        end
        else
        begin : g_zero
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    row_reg <= '0;
            end
        end
        assign rows[r] = row_reg;
    end

    assign cfg.norm_a  = normal_reg[15:0];
    assign cfg.norm_b  = normal_reg[31:16];
    assign cfg.norm_c  = normal_reg[47:32];
    assign cfg.offset  = offset_reg;
    assign cfg.lim_cnt = lcount_reg;
    assign cfg.tol     = tol_reg;

endmodule

@@ rtl/bpri_front.sv @@
module bpri_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          ray_valid,
    input  bpri_pkg::ray_t                ray,
    input  bpri_pkg::cfg_t                cfg,
    output logic                          div_valid,
    output logic [bpri_pkg::NUM_W-1:0]    div_num,
    output logic [bpri_pkg::DEN_W-1:0]    div_den,
    output bpri_pkg::ctx_t                div_ctx
);

    localparam int DW = bpri_pkg::DEN_W;
    localparam int NW = bpri_pkg::NN_W;

    // Stage 1: normal times direction and origin
    logic               s1_valid_reg;
    bpri_pkg::ray_t     s1_ray_reg;
    logic signed [47:0] pv_reg [3];
    logic signed [47:0] po_reg [3];
    logic signed [47:0] pv_next [3];
    logic signed [47:0] po_next [3];

    always_comb
    begin
        pv_next[0] = $signed(cfg.norm_a) * $signed(ray.dir_x);
        pv_next[1] = $signed(cfg.norm_b) * $signed(ray.dir_y);
        pv_next[2] = $signed(cfg.norm_c) * $signed(ray.dir_z);
        po_next[0] = $signed(cfg.norm_a) * $signed(ray.origin_x);
        po_next[1] = $signed(cfg.norm_b) * $signed(ray.origin_y);
        po_next[2] = $signed(cfg.norm_c) * $signed(ray.origin_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= ray_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ray_reg <= ray;
            pv_reg     <= pv_next;
            po_reg     <= po_next;
        end
    end

    // Stage 2: sums, parallel test, operand magnitudes for the divider
    logic signed [49:0]   sv;
    logic signed [50:0]   so;
    logic signed [DW-1:0] dn;
    logic signed [NW-1:0] nn;
    logic [DW-1:0]        dn_mag;
    logic [NW-1:0]        nn_mag;
    bpri_pkg::ctx_t       ctx_next;

    always_comb
    begin
        sv = 50'(pv_reg[0]) + 50'(pv_reg[1]) + 50'(pv_reg[2]);
        so = 51'(po_reg[0]) + 51'(po_reg[1]) + 51'(po_reg[2])
           + (51'(cfg.offset) <<< 14);
        dn = DW'(sv >>> 14);
        nn = NW'(so >>> 14);
        dn_mag = dn[DW-1] ? DW'(-dn) : DW'(dn);
        nn_mag = nn[NW-1] ? NW'(-nn) : NW'(nn);
        ctx_next.ray  = s1_ray_reg;
        ctx_next.par  = dn_mag <= DW'(cfg.tol);
        ctx_next.flip = !dn[DW-1] && (dn != '0);
        // numerator is -nn, so it is negative when nn is positive
        ctx_next.qneg = (!nn[NW-1] && (nn != '0)) ^ dn[DW-1];
    end

    logic                         s2_valid_reg;
    logic [bpri_pkg::NUM_W-1:0]   num_reg;
    logic [DW-1:0]                den_reg;
    bpri_pkg::ctx_t               ctx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg <= {nn_mag, 16'b0};
            den_reg <= dn_mag;
            ctx_reg <= ctx_next;
        end
    end

    assign div_valid = s2_valid_reg;
    assign div_num   = num_reg;
    assign div_den   = den_reg;
    assign div_ctx   = ctx_reg;

endmodule

@@ rtl/bpri_div.sv @@
`include "bounded_plane_ray_intersect_defines.svh"

module bpri_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [bpri_pkg::NUM_W-1:0]    in_num,
    input  logic [bpri_pkg::DEN_W-1:0]    in_den,
    input  bpri_pkg::ctx_t                in_ctx,
    output logic                          out_valid,
    output logic [bpri_pkg::NUM_W-1:0]    out_quo,
    output bpri_pkg::ctx_t                out_ctx
);

    localparam int DW = bpri_pkg::DEN_W;
    localparam int NW = bpri_pkg::NUM_W;

    // One restoring step per stage, quotient bit shifted in at the bottom
    logic          valid_reg [NW];
    logic [DW-1:0] rem_reg   [NW];
    logic [NW-1:0] acc_reg   [NW];
    logic [DW-1:0] den_reg   [NW];
    bpri_pkg::ctx_t ctx_reg  [NW];

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic           v_prev;
        logic [DW-1:0]  rem_prev;
        logic [NW-1:0]  acc_prev;
        logic [DW-1:0]  den_prev;
        bpri_pkg::ctx_t ctx_prev;
        logic [DW:0]    trial;
        logic           ge;
        logic [DW-1:0]  rem_next;

        if (i == 0)
        begin : g_first
            assign v_prev   = in_valid;
            assign rem_prev = '0;
            assign acc_prev = in_num;
            assign den_prev = in_den;
            assign ctx_prev = in_ctx;
        end
        else
        begin : g_rest
            assign v_prev   = valid_reg[i-1];
            assign rem_prev = rem_reg[i-1];
            assign acc_prev = acc_reg[i-1];
            assign den_prev = den_reg[i-1];
            assign ctx_prev = ctx_reg[i-1];
        end

        always_comb
        begin
            trial    = {rem_prev, acc_prev[NW-1]};
            ge       = trial >= {1'b0, den_prev};
            rem_next = ge ? DW'(trial - {1'b0, den_prev}) : trial[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (adv)
                valid_reg[i] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i] <= rem_next;
                acc_reg[i] <= {acc_prev[NW-2:0], ge};
                den_reg[i] <= den_prev;
                ctx_reg[i] <= ctx_prev;
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign out_quo   = acc_reg[NW-1];
    assign out_ctx   = ctx_reg[NW-1];

    `BPRI_ASSERT_IMP(a_rem_below_den, valid_reg[NW-1] && den_reg[NW-1] != '0, rem_reg[NW-1] < den_reg[NW-1], "divider remainder not below divisor")
    `BPRI_ASSERT_NXT(a_tail_holds, valid_reg[NW-1] && !adv, valid_reg[NW-1] && $stable(acc_reg[NW-1]), "divider tail lost a beat while held")

endmodule

@@ rtl/bpri_back.sv @@
module bpri_back #(
    parameter int MAX_LIMITS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [bpri_pkg::NUM_W-1:0]    in_quo,
    input  bpri_pkg::ctx_t                in_ctx,
    input  bpri_pkg::cfg_t                cfg,
    input  logic [63:0]                   rows [MAX_LIMITS],
    output logic                          out_valid,
    output bpri_pkg::hit_t                out_hit
);

    localparam int NW = bpri_pkg::NUM_W;
    localparam int TW = NW + 1;

    // Stage T: signed t, behind and range checks
    logic signed [TW-1:0] tw;
    logic signed [TW-1:0] ntol_t;
    logic [2:0]           st_t;

    always_comb
    begin
        tw     = in_ctx.qneg ? -$signed({1'b0, in_quo}) : $signed({1'b0, in_quo});
        ntol_t = -$signed(TW'(cfg.tol));
        if (in_ctx.par)
            st_t = bpri_pkg::ST_PAR;
        else if (tw < ntol_t)
            st_t = bpri_pkg::ST_BEHIND;
        else if (!((tw[TW-1:31] == '0) || (tw[TW-1:31] == '1)))
            st_t = bpri_pkg::ST_OVF;
        else
            st_t = bpri_pkg::ST_HIT;
    end

    logic               t_valid_reg;
    logic [2:0]         t_st_reg;
    logic signed [31:0] t_reg;
    bpri_pkg::ray_t     t_ray_reg;
    logic               t_flip_reg;

    // Stage M: direction times t
    logic               m_valid_reg;
    logic [2:0]         m_st_reg;
    logic signed [31:0] m_t_reg;
    bpri_pkg::ray_t     m_ray_reg;
    logic               m_flip_reg;
    logic signed [63:0] vt_reg   [3];
    logic signed [63:0] vt_next  [3];

    always_comb
    begin
        vt_next[0] = $signed(t_ray_reg.dir_x) * t_reg;
        vt_next[1] = $signed(t_ray_reg.dir_y) * t_reg;
        vt_next[2] = $signed(t_ray_reg.dir_z) * t_reg;
    end

    // Stage P: hit point and its range check
    logic signed [48:0] pw [3];
    logic               p_ovf;
    logic [2:0]         st_p;

    always_comb
    begin
        pw[0] = 49'($signed(m_ray_reg.origin_x)) + 49'(vt_reg[0] >>> 16);
        pw[1] = 49'($signed(m_ray_reg.origin_y)) + 49'(vt_reg[1] >>> 16);
        pw[2] = 49'($signed(m_ray_reg.origin_z)) + 49'(vt_reg[2] >>> 16);
        p_ovf = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (!((pw[k][48:31] == '0) || (pw[k][48:31] == '1)))
                p_ovf = 1'b1;
        end
        st_p = (m_st_reg == bpri_pkg::ST_HIT && p_ovf) ? bpri_pkg::ST_OVF : m_st_reg;
    end

    logic               p_valid_reg;
    logic [2:0]         p_st_reg;
    logic signed [31:0] p_t_reg;
    logic               p_flip_reg;
    logic signed [31:0] p_reg [3];

    // Stage Q: plane and limit products on the point
    logic signed [47:0] np_next [3];
    logic signed [42:0] ep_next [MAX_LIMITS][3];

    always_comb
    begin
        np_next[0] = $signed(cfg.norm_a) * p_reg[0];
        np_next[1] = $signed(cfg.norm_b) * p_reg[1];
        np_next[2] = $signed(cfg.norm_c) * p_reg[2];
        for (int r = 0; r < MAX_LIMITS; r++)
        begin
            ep_next[r][0] = $signed(rows[r][10:0])  * p_reg[0];
            ep_next[r][1] = $signed(rows[r][21:11]) * p_reg[1];
            ep_next[r][2] = $signed(rows[r][32:22]) * p_reg[2];
        end
    end

    logic               q_valid_reg;
    logic [2:0]         q_st_reg;
    logic signed [31:0] q_t_reg;
    logic               q_flip_reg;
    logic signed [31:0] q_p_reg [3];
    logic signed [47:0] np_reg  [3];
    logic signed [42:0] ep_reg  [MAX_LIMITS][3];

    // Stage S: tolerance compares, final status, zero fields on a miss
    logic signed [50:0] ps;
    logic signed [36:0] s_plane;
    logic signed [44:0] ls;
    logic signed [35:0] s_lim;
    logic signed [36:0] ptol37;
    logic signed [36:0] ntol37;
    logic signed [35:0] ptol36;
    logic signed [35:0] ntol36;
    logic               fail;
    logic [2:0]         st_s;
    bpri_pkg::hit_t     hit_next;

    always_comb
    begin
        ptol37  = $signed(37'(cfg.tol));
        ntol37  = -ptol37;
        ptol36  = $signed(36'(cfg.tol));
        ntol36  = -ptol36;
        ps      = 51'(np_reg[0]) + 51'(np_reg[1]) + 51'(np_reg[2])
                + (51'(cfg.offset) <<< 14);
        s_plane = 37'(ps >>> 14);
        fail    = (s_plane > ptol37) || (s_plane < ntol37);
        ls      = '0;
        s_lim   = '0;
        for (int r = 0; r < MAX_LIMITS; r++)
        begin
            ls    = 45'(ep_reg[r][0]) + 45'(ep_reg[r][1]) + 45'(ep_reg[r][2])
                  + (45'($signed(rows[r][62:33])) <<< 9);
            s_lim = 36'(ls >>> 9);
            if (r < 32'(cfg.lim_cnt))
            begin
                if (rows[r][63] ? (s_lim < ntol36) : (s_lim > ptol36))
                    fail = 1'b1;
            end
        end
        st_s = (q_st_reg == bpri_pkg::ST_HIT && fail) ? bpri_pkg::ST_OUTSIDE : q_st_reg;
        hit_next = '0;
        hit_next.status = st_s;
        if (st_s == bpri_pkg::ST_HIT)
        begin
            hit_next.hit_t          = q_t_reg;
            hit_next.hit_x          = q_p_reg[0];
            hit_next.hit_y          = q_p_reg[1];
            hit_next.hit_z          = q_p_reg[2];
            hit_next.normal_flipped = q_flip_reg;
        end
    end

    logic           s_valid_reg;
    bpri_pkg::hit_t hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t_valid_reg <= in_valid;
            m_valid_reg <= t_valid_reg;
            p_valid_reg <= m_valid_reg;
            q_valid_reg <= p_valid_reg;
            s_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_st_reg   <= st_t;
            t_reg      <= tw[31:0];
            t_ray_reg  <= in_ctx.ray;
            t_flip_reg <= in_ctx.flip;

            m_st_reg   <= t_st_reg;
            m_t_reg    <= t_reg;
            m_ray_reg  <= t_ray_reg;
            m_flip_reg <= t_flip_reg;
            vt_reg     <= vt_next;

            p_st_reg   <= st_p;
            p_t_reg    <= m_t_reg;
            p_flip_reg <= m_flip_reg;
            for (int k = 0; k < 3; k++)
                p_reg[k] <= pw[k][31:0];

            q_st_reg   <= p_st_reg;
            q_t_reg    <= p_t_reg;
            q_flip_reg <= p_flip_reg;
            q_p_reg    <= p_reg;
            np_reg     <= np_next;
            ep_reg     <= ep_next;

            hit_reg    <= hit_next;
        end
    end

    assign out_valid = s_valid_reg;
    assign out_hit   = hit_reg;

endmodule

@@ rtl/bounded_plane_ray_intersect.sv @@
// Ray against bounded plane: each beat on the ray channel carries one ray
// (origin and direction, Q16.16) and produces exactly one beat on the hit
// channel, in order. The pipeline accepts one ray per clock while the hit
// channel is not stalled with a beat waiting. The front stages form the dot
// products and the parallel test, the pipelined restoring divider (one
// quotient bit per stage) yields t, and the back stages form the hit point,
// the range checks and the plane and limit compares. The last stage is the
// output register. While the hit channel is stalled with a beat waiting,
// the whole pipeline holds and ray_stall is raised; nothing is dropped or
// repeated. Configuration registers are read live, so write them only
// while no ray is in flight.
`include "bounded_plane_ray_intersect_defines.svh"

module bounded_plane_ray_intersect #(
    parameter int MAX_LIMITS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    // ray channel
    input  logic              ray_valid,
    output logic              ray_stall,
    input  bpri_pkg::ray_t    ray,
    // result channel
    output logic              hit_valid,
    input  logic              hit_stall,
    output bpri_pkg::hit_t    hit
);

    bpri_pkg::cfg_t cfg;
    logic [63:0]    rows [MAX_LIMITS];

    // Advance the whole pipe unless a finished beat waits on a stalled sink
    logic adv;
    assign adv       = !hit_valid || !hit_stall;
    assign ray_stall = !adv;

    bpri_cfg #(
        .MAX_LIMITS (MAX_LIMITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .rows      (rows)
    );

    logic                          fr_valid;
    logic [bpri_pkg::NUM_W-1:0]    fr_num;
    logic [bpri_pkg::DEN_W-1:0]    fr_den;
    bpri_pkg::ctx_t                fr_ctx;

    bpri_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ray_valid (ray_valid),
        .ray       (ray),
        .cfg       (cfg),
        .div_valid (fr_valid),
        .div_num   (fr_num),
        .div_den   (fr_den),
        .div_ctx   (fr_ctx)
    );

    logic                          dv_valid;
    logic [bpri_pkg::NUM_W-1:0]    dv_quo;
    bpri_pkg::ctx_t                dv_ctx;

    bpri_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_num    (fr_num),
        .in_den    (fr_den),
        .in_ctx    (fr_ctx),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_ctx   (dv_ctx)
    );

    bpri_back #(
        .MAX_LIMITS (MAX_LIMITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dv_valid),
        .in_quo    (dv_quo),
        .in_ctx    (dv_ctx),
        .cfg       (cfg),
        .rows      (rows),
        .out_valid (hit_valid),
        .out_hit   (hit)
    );

    // A miss carries no geometry
    `BPRI_ASSERT_IMP(a_miss_zero, hit_valid && hit.status != bpri_pkg::ST_HIT, hit.hit_t == '0 && hit.hit_x == '0 && hit.hit_y == '0 && hit.hit_z == '0 && !hit.normal_flipped, "miss beat carries nonzero fields")
    // Status stays within the defined codes
    `BPRI_ASSERT_IMP(a_status_code, hit_valid, hit.status <= bpri_pkg::ST_OVF, "undefined status code")
    // A hit never lies behind the origin beyond tolerance
    `BPRI_ASSERT_IMP(a_hit_ahead, hit_valid && hit.status == bpri_pkg::ST_HIT, $signed({hit.hit_t[31], hit.hit_t}) >= -$signed({17'b0, cfg.tol}), "hit reported behind origin")

endmodule
